@@ rtl/lzcd_pkg.sv @@
`default_nettype none

package lzcd_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int COORD_W       = 11;
  localparam int IMG_W_BITS    = 12;
  localparam int THR_BITS      = 19;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = IMG_W_BITS'(640);
  localparam logic [THR_BITS-1:0]   THR_RESET   = THR_BITS'(41);

  localparam logic MODE_QUAD = 1'b0;
  localparam logic MODE_RING = 1'b1;
  localparam logic MODE_RESET = MODE_QUAD;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_NEIGHBOR_MODE  = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } reg_idx_t;

  // quadrant sums of four samples need two guard bits
  localparam int SUM_W  = SAMPLE_BITS + 2;
  localparam int DIFF_W = SUM_W + 1;
  localparam int CMP_W  = ((DIFF_W > THR_BITS) ? DIFF_W : THR_BITS) + 1;
  localparam int NCAND  = 8;

  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef smp_t [2:0][2:0]               win_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_start;
  } in_item_t;

  typedef struct packed {
    logic               edge_res;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_column;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } coord_t;

  typedef struct packed {
    logic   ev;
    coord_t pos;
  } tag_t;

  typedef struct packed {
    logic a_ev;
    logic b_ev;
    logic c_ev;
  } jdg_status_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } jdg_out_t;

endpackage

`default_nettype wire

@@ rtl/log_zero_crossing_detector.sv @@
// Throughput: one sample per cycle while in_ready is high; the line store is
// read at acceptance and written back the next cycle, with forwarding when
// both hit the same column. A small result queue lets samples keep flowing
// while out_ready is low. Reset (rst_n, synchronous): counters, window and
// queue clear, registers take their defaults; the line store is not cleared
// and needs no clearing pass.
`default_nettype none

module log_zero_crossing_detector #(
  parameter int MAX_WIDTH  = lzcd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lzcd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lzcd_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lzcd_pkg::out_item_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lzcd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lzcd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lzcd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lzcd_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WE_W   = $clog2(MAX_WIDTH + 1);
  localparam int EW     = ((WE_W > IMG_W_BITS) ? WE_W : IMG_W_BITS) + 1;
  localparam int RX_W   = (ROW_W > COORD_W) ? ROW_W : COORD_W;
  localparam int CX_W   = (COL_W > COORD_W) ? COL_W : COORD_W;
  localparam int ENT_W  = 2 * SAMPLE_BITS;
  localparam int PEND_W = OQ_CNT_W + 1;

  // configuration registers
  logic [IMG_W_BITS-1:0] img_w_r;
  logic                  mode_r;
  logic [THR_BITS-1:0]   thr_r;
  logic                  cfg_wr;
  reg_idx_t              reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_W_RESET;
      mode_r  <= MODE_RESET;
      thr_r   <= THR_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:    img_w_r <= pwdata[IMG_W_BITS-1:0];
        REG_NEIGHBOR_MODE:  mode_r  <= pwdata[0];
        REG_EDGE_THRESHOLD: thr_r   <= pwdata[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:    prdata = APB_DATA_W'(img_w_r);
      REG_NEIGHBOR_MODE:  prdata = APB_DATA_W'(mode_r);
      REG_EDGE_THRESHOLD: prdata = APB_DATA_W'(thr_r);
      default:            prdata = '0;
    endcase
  end

  // raster position
  logic [COL_W-1:0] col_cnt_r, col_nxt, x_cur;
  logic [ROW_W-1:0] row_cnt_r, row_nxt, y_cur;
  logic [EW-1:0]    img_w_ext, w_eff;
  logic             row_end, emit, accept;
  logic [RX_W-1:0]  row_m1;
  logic [CX_W-1:0]  col_m1;
  coord_t           pos_cur;

  assign accept    = in_valid && in_ready;
  assign img_w_ext = EW'(img_w_r);

  always_comb begin
    priority if (img_w_ext < EW'(3)) w_eff = EW'(3);
    else if (img_w_ext > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
    else w_eff = img_w_ext;
  end

  always_comb begin
    x_cur   = in_data.frame_start ? '0 : col_cnt_r;
    y_cur   = in_data.frame_start ? '0 : row_cnt_r;
    row_end = (EW'(x_cur) + EW'(1)) >= w_eff;
    emit    = (y_cur >= ROW_W'(2)) && (x_cur >= COL_W'(2));
    row_m1  = RX_W'(y_cur) - RX_W'(1);
    col_m1  = CX_W'(x_cur) - CX_W'(1);
    pos_cur.row = row_m1[COORD_W-1:0];
    pos_cur.col = col_m1[COORD_W-1:0];
    if (row_end) begin
      col_nxt = '0;
      row_nxt = (y_cur < ROW_W'(MAX_HEIGHT - 1)) ? y_cur + ROW_W'(1) : y_cur;
    end else begin
      col_nxt = x_cur + COL_W'(1);
      row_nxt = y_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      col_cnt_r <= col_nxt;
      row_cnt_r <= row_nxt;
    end
  end

  // line store: each entry holds {row y-2, row y-1} of one column
  logic [ENT_W-1:0]       lmem [MAX_WIDTH];
  logic [ENT_W-1:0]       rd_r;
  logic [ENT_W-1:0]       wr_ent;
  smp_t                   rd_up, rd_mid;
  logic                   fwd;

  logic                   s1_v_r, s1_ev_r;
  smp_t                   s1_sample_r;
  logic [COL_W-1:0]       s1_idx_r;
  coord_t                 s1_pos_r;

  assign rd_up  = rd_r[ENT_W-1 -: SAMPLE_BITS];
  assign rd_mid = rd_r[SAMPLE_BITS-1:0];
  assign wr_ent = {rd_mid, s1_sample_r};
  // write-back of the previous transaction lands in the same column
  assign fwd    = s1_v_r && (s1_idx_r == x_cur);

  always_ff @(posedge clk) begin
    if (s1_v_r) lmem[s1_idx_r] <= wr_ent;
    if (accept) begin
      if (fwd) rd_r <= wr_ent;
      else     rd_r <= lmem[x_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s1_ev_r <= 1'b0;
    end else begin
      s1_v_r  <= accept;
      s1_ev_r <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= in_data.sample;
      s1_idx_r    <= x_cur;
      s1_pos_r    <= pos_cur;
    end
  end

  // 3x3 window, shifted left once per transaction
  win_t win_r;
  tag_t tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      tag_r.ev <= 1'b0;
    end else begin
      tag_r.ev <= s1_ev_r;
      if (s1_v_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= rd_up;
        win_r[1][2] <= rd_mid;
        win_r[2][2] <= s1_sample_r;
      end
    end
    tag_r.pos <= s1_pos_r;
  end

  jdg_status_t jdg_st;
  jdg_out_t    jdg_res;

  lzcd_judge u_judge (
    .clk      (clk),
    .rst_n    (rst_n),
    .win_i    (win_r),
    .mode_i   (mode_r),
    .thr_i    (thr_r),
    .tag_i    (tag_r),
    .status_o (jdg_st),
    .res_o    (jdg_res)
  );

  // result queue
  out_item_t           oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wp_r, oq_rp_r;
  logic [OQ_CNT_W-1:0] oq_cnt_r;
  logic                push, pop;
  logic [PEND_W-1:0]   pend;

  assign push      = jdg_res.valid;
  assign pop       = out_valid && out_ready;
  assign out_valid = oq_cnt_r != '0;
  assign out_data  = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (push) oq_r[oq_wp_r] <= jdg_res.item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (push) oq_wp_r <= oq_wp_r + OQ_PTR_W'(1);
      if (pop)  oq_rp_r <= oq_rp_r + OQ_PTR_W'(1);
      unique case ({push, pop})
        2'b10:   oq_cnt_r <= oq_cnt_r + OQ_CNT_W'(1);
        2'b01:   oq_cnt_r <= oq_cnt_r - OQ_CNT_W'(1);
        default: oq_cnt_r <= oq_cnt_r;
      endcase
    end
  end

  // reserve a queue slot for every result still in flight
  always_comb begin
    pend = PEND_W'(s1_ev_r) + PEND_W'(tag_r.ev) + PEND_W'(jdg_st.a_ev)
         + PEND_W'(jdg_st.b_ev) + PEND_W'(jdg_st.c_ev) + PEND_W'(oq_cnt_r);
  end

  assign in_ready = pend < PEND_W'(OQ_DEPTH);

  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (oq_cnt_r != OQ_CNT_W'(OQ_DEPTH)))
    else $error("result queue written while full");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend <= PEND_W'(OQ_DEPTH))
    else $error("more results in flight than queue slots");

  a_fwd_data: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fwd) |=> (rd_r === $past(wr_ent)))
    else $error("forwarded line store entry lost");

endmodule

`default_nettype wire

@@ rtl/lzcd_judge.sv @@
`default_nettype none

module lzcd_judge (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lzcd_pkg::win_t                 win_i,
  input  logic                           mode_i,
  input  logic [lzcd_pkg::THR_BITS-1:0]  thr_i,
  input  lzcd_pkg::tag_t                 tag_i,
  output lzcd_pkg::jdg_status_t          status_o,
  output lzcd_pkg::jdg_out_t             res_o
);
  import lzcd_pkg::*;

  function automatic sum_t sx(input smp_t s);
    return sum_t'(s);
  endfunction

  sum_t      cand_nxt [NCAND];
  sum_t      cand_r   [NCAND];
  sum_t      quad     [4];
  sum_t      hi1 [4];
  sum_t      lo1 [4];
  sum_t      hi2 [2];
  sum_t      lo2 [2];
  sum_t      hi_nxt, lo_nxt;
  sum_t      hi_r, lo_r;
  logic      a_ev_r, b_ev_r, c_ev_r;
  coord_t    a_pos_r, b_pos_r;
  out_item_t res_item_r;

  logic signed [CMP_W-1:0] spread;
  logic signed [CMP_W-1:0] thr_ext;
  logic                    edge_nxt;

  // stage A: candidate values
  always_comb begin
    quad[0] = sx(win_i[1][1]) + sx(win_i[0][1]) + sx(win_i[0][0]) + sx(win_i[1][0]);
    quad[1] = sx(win_i[1][1]) + sx(win_i[1][0]) + sx(win_i[2][0]) + sx(win_i[2][1]);
    quad[2] = sx(win_i[1][1]) + sx(win_i[2][1]) + sx(win_i[2][2]) + sx(win_i[1][2]);
    quad[3] = sx(win_i[1][1]) + sx(win_i[1][2]) + sx(win_i[0][2]) + sx(win_i[0][1]);
    unique case (mode_i)
      MODE_QUAD: begin
        for (int k = 0; k < 4; k++) begin
          cand_nxt[k]     = quad[k];
          cand_nxt[k + 4] = quad[k];
        end
      end
      MODE_RING: begin
        cand_nxt[0] = sx(win_i[0][0]);
        cand_nxt[1] = sx(win_i[0][1]);
        cand_nxt[2] = sx(win_i[0][2]);
        cand_nxt[3] = sx(win_i[1][0]);
        cand_nxt[4] = sx(win_i[1][2]);
        cand_nxt[5] = sx(win_i[2][0]);
        cand_nxt[6] = sx(win_i[2][1]);
        cand_nxt[7] = sx(win_i[2][2]);
      end
      default: begin
        for (int k = 0; k < NCAND; k++) cand_nxt[k] = '0;
      end
    endcase
  end

  // stage B: max / min tree
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hi1[k] = (cand_r[2*k] > cand_r[2*k+1]) ? cand_r[2*k] : cand_r[2*k+1];
      lo1[k] = (cand_r[2*k] < cand_r[2*k+1]) ? cand_r[2*k] : cand_r[2*k+1];
    end
    for (int k = 0; k < 2; k++) begin
      hi2[k] = (hi1[2*k] > hi1[2*k+1]) ? hi1[2*k] : hi1[2*k+1];
      lo2[k] = (lo1[2*k] < lo1[2*k+1]) ? lo1[2*k] : lo1[2*k+1];
    end
    hi_nxt = (hi2[0] > hi2[1]) ? hi2[0] : hi2[1];
    lo_nxt = (lo2[0] < lo2[1]) ? lo2[0] : lo2[1];
  end

  // stage C: sign change and spread check
  always_comb begin
    spread   = CMP_W'(hi_r) - CMP_W'(lo_r);
    thr_ext  = $signed(CMP_W'(thr_i));
    edge_nxt = (hi_r > 0) && (lo_r < 0) && (spread > thr_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ev_r <= 1'b0;
      b_ev_r <= 1'b0;
      c_ev_r <= 1'b0;
    end else begin
      a_ev_r <= tag_i.ev;
      b_ev_r <= a_ev_r;
      c_ev_r <= b_ev_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NCAND; k++) cand_r[k] <= cand_nxt[k];
    a_pos_r                 <= tag_i.pos;
    hi_r                    <= hi_nxt;
    lo_r                    <= lo_nxt;
    b_pos_r                 <= a_pos_r;
    res_item_r.edge_res     <= edge_nxt;
    res_item_r.pixel_row    <= b_pos_r.row;
    res_item_r.pixel_column <= b_pos_r.col;
  end

  assign status_o.a_ev = a_ev_r;
  assign status_o.b_ev = b_ev_r;
  assign status_o.c_ev = c_ev_r;
  assign res_o.valid   = c_ev_r;
  assign res_o.item    = res_item_r;

endmodule

`default_nettype wire

@@ tb/sv/tb_log_zero_crossing_detector.sv @@
module tb_log_zero_crossing_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import lzcd_pkg::*;

  localparam int CYCLE_LIMIT   = 500_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 460;
  localparam int PRIME_WIDTH   = 120;
  localparam int THR_MAX       = (1 << THR_BITS) - 1;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

  typedef enum logic [1:0] {MIX_FULL, MIX_TINY, MIX_MID, MIX_POSITIVE} sample_mix_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] value;
    smp_t        sample;
    logic        frame_start;
    logic        known;
    out_item_t   result;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // raster model state
  smp_t                  upper_line [MAX_WIDTH_DEF];
  smp_t                  middle_line [MAX_WIDTH_DEF];
  smp_t                  cells [3][3];
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [IMG_W_BITS-1:0] width_reg;
  logic                  mode_reg;
  logic [THR_BITS-1:0]   threshold_reg;

  out_item_t             expected_results[$];
  script_row_t           directed_rows[$];
  int                    mismatch_count;
  int                    cycle_count;
  int                    in_gap_max;
  int                    out_stall_max;

  log_zero_crossing_detector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("log_zero_crossing_detector verification failed");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  function automatic logic zero_crossing_at_center();
    longint cand[8];
    longint hi;
    longint lo;
    int     n;
    int     k;
    if (mode_reg == MODE_QUAD) begin
      cand[0] = longint'(cells[1][1]) + cells[0][1] + cells[0][0] + cells[1][0];
      cand[1] = longint'(cells[1][1]) + cells[1][0] + cells[2][0] + cells[2][1];
      cand[2] = longint'(cells[1][1]) + cells[2][1] + cells[2][2] + cells[1][2];
      cand[3] = longint'(cells[1][1]) + cells[1][2] + cells[0][2] + cells[0][1];
      n = 4;
    end else begin
      cand[0] = cells[0][0];
      cand[1] = cells[0][1];
      cand[2] = cells[0][2];
      cand[3] = cells[1][0];
      cand[4] = cells[1][2];
      cand[5] = cells[2][0];
      cand[6] = cells[2][1];
      cand[7] = cells[2][2];
      n = 8;
    end
    hi = cand[0];
    lo = cand[0];
    for (k = 1; k < n; k++) begin
      if (cand[k] > hi) hi = cand[k];
      if (cand[k] < lo) lo = cand[k];
    end
    return hi > 0 && lo < 0 && (hi - lo) > longint'(threshold_reg);
  endfunction

  // shift one sample into the line stores and window, judge the center if interior
  function automatic void advance_raster(input in_item_t item, output logic produced,
                                         output out_item_t result);
    int unsigned ew;
    int unsigned x;
    int unsigned y;
    int unsigned idx;
    smp_t        up;
    smp_t        mid;
    ew = (width_reg < 3) ? 3 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
    if (item.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    x = col_pos;
    y = row_pos;
    idx = (x < MAX_WIDTH_DEF) ? x : MAX_WIDTH_DEF - 1;
    up = upper_line[idx];
    mid = middle_line[idx];
    upper_line[idx] = mid;
    middle_line[idx] = item.sample;
    for (int r = 0; r < 3; r++) begin
      cells[r][0] = cells[r][1];
      cells[r][1] = cells[r][2];
    end
    cells[0][2] = up;
    cells[1][2] = mid;
    cells[2][2] = item.sample;
    produced = (y >= 2 && x >= 2);
    result = '0;
    if (produced) begin
      result.edge_res     = zero_crossing_at_center();
      result.pixel_row    = COORD_W'(y - 1);
      result.pixel_column = COORD_W'(x - 1);
    end
    if (x + 1 >= ew) begin
      col_pos = 0;
      if (row_pos < MAX_HEIGHT_DEF - 1) row_pos++;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  function automatic smp_t draw_sample(input sample_mix_t mix);
    case (mix)
      MIX_FULL: return smp_t'($urandom());
      MIX_TINY: return smp_t'(int'($urandom_range(0, 128)) - 64);
      MIX_MID:  return smp_t'(int'($urandom_range(0, 8192)) - 4096);
      default: begin
        if ($urandom_range(0, 15) == 0) return smp_t'(-int'($urandom_range(1, 32768)));
        return smp_t'($urandom_range(0, 32767));
      end
    endcase
  endfunction

  function automatic script_row_t pix(input int value, input logic fs = 1'b0);
    script_row_t r;
    r = '0;
    r.kind = ROW_PIXEL;
    r.sample = smp_t'(value);
    r.frame_start = fs;
    return r;
  endfunction

  function automatic script_row_t pix_known(input int value, input logic crossing,
                                            input int row, input int col);
    script_row_t r;
    r = pix(value);
    r.known = 1'b1;
    r.result.edge_res = crossing;
    r.result.pixel_row = COORD_W'(row);
    r.result.pixel_column = COORD_W'(col);
    return r;
  endfunction

  function automatic script_row_t reg_row(input reg_idx_t idx, input int unsigned value);
    script_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  task automatic apb_transfer(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input reg_idx_t idx, input logic [31:0] wanted);
    logic [31:0] got;
    logic [31:0] mask;
    apb_transfer(1'b0, idx, '0, got);
    case (idx)
      REG_IMAGE_WIDTH:   mask = (32'd1 << IMG_W_BITS) - 1;
      REG_NEIGHBOR_MODE: mask = 32'd1;
      default:           mask = (32'd1 << THR_BITS) - 1;
    endcase
    if ((got & mask) != (wanted & mask)) begin
      note_mismatch($sformatf("register %s reads %0d, wanted %0d", idx.name(), got & mask,
                              wanted & mask));
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] ignored;
    apb_transfer(1'b1, idx, value, ignored);
    case (idx)
      REG_IMAGE_WIDTH:   width_reg = value[IMG_W_BITS-1:0];
      REG_NEIGHBOR_MODE: mode_reg = value[0];
      default:           threshold_reg = value[THR_BITS-1:0];
    endcase
    check_reg(idx, value);
  endtask

  // drop valid and hold until every result is out and the pipeline has emptied
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pixel(input smp_t value, input logic fs, input logic known,
                            input out_item_t typed);
    int        gap;
    logic      produced;
    out_item_t predicted;
    in_item_t  item;
    gap = $urandom_range(0, in_gap_max);
    item.sample = value;
    item.frame_start = fs;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    advance_raster(item, produced, predicted);
    if (produced) expected_results.push_back(known ? typed : predicted);
    @(negedge clk);
  endtask

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid && out_ready) begin : compare_result
      out_item_t want;
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected transaction row %0d col %0d edge %0b",
                                out_data.pixel_row, out_data.pixel_column, out_data.edge_res));
      end else begin
        want = expected_results.pop_front();
        if (out_data.pixel_row !== want.pixel_row) begin
          note_mismatch($sformatf("pixel_row %0d, wanted %0d", out_data.pixel_row,
                                  want.pixel_row));
        end
        if (out_data.pixel_column !== want.pixel_column) begin
          note_mismatch($sformatf("pixel_column %0d, wanted %0d", out_data.pixel_column,
                                  want.pixel_column));
        end
        if (out_data.edge_res !== want.edge_res) begin
          note_mismatch($sformatf("edge_res %0b at (%0d,%0d), wanted %0b", out_data.edge_res,
                                  want.pixel_row, want.pixel_column, want.edge_res));
        end
      end
    end
  end

  initial begin : stimulus
    int          n;
    int          count;
    int          span;
    int          reshape_at;
    int          random_items;
    logic        restart;
    int unsigned new_width;
    int unsigned new_threshold;
    sample_mix_t mix;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_gap_max = 11;
    out_stall_max = 11;
    mismatch_count = 0;
    cycle_count = 0;
    random_items = 0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    foreach (cells[r, c]) cells[r][c] = '0;
    col_pos = 0;
    row_pos = 0;
    width_reg = 640;
    mode_reg = MODE_QUAD;
    threshold_reg = 41;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    check_reg(REG_IMAGE_WIDTH, 640);
    check_reg(REG_NEIGHBOR_MODE, MODE_QUAD);
    check_reg(REG_EDGE_THRESHOLD, 41);

    // width below the minimum acts as three columns
    directed_rows.push_back(reg_row(REG_IMAGE_WIDTH, 0));
    directed_rows.push_back(reg_row(REG_NEIGHBOR_MODE, MODE_QUAD));
    directed_rows.push_back(reg_row(REG_EDGE_THRESHOLD, 0));
    directed_rows.push_back(pix(0, 1'b1));
    directed_rows.push_back(pix(0));
    directed_rows.push_back(pix(0));
    directed_rows.push_back(pix(0));
    directed_rows.push_back(pix(0));
    directed_rows.push_back(pix(0));
    directed_rows.push_back(pix(0));
    directed_rows.push_back(pix(0));
    directed_rows.push_back(pix_known(0, 1'b0, 1, 1));
    directed_rows.push_back(pix(32767));
    directed_rows.push_back(pix(-32768));
    directed_rows.push_back(pix(32767));
    directed_rows.push_back(pix(-32768));
    directed_rows.push_back(pix(32767));
    directed_rows.push_back(pix(-32768));
    // top threshold: no spread of 16-bit samples can exceed it
    directed_rows.push_back(reg_row(REG_NEIGHBOR_MODE, MODE_RING));
    directed_rows.push_back(reg_row(REG_EDGE_THRESHOLD, THR_MAX));
    directed_rows.push_back(pix(32767));
    directed_rows.push_back(pix(32767));
    directed_rows.push_back(pix_known(32767, 1'b0, 4, 1));
    directed_rows.push_back(reg_row(REG_EDGE_THRESHOLD, 0));
    directed_rows.push_back(pix(-4096));
    directed_rows.push_back(pix(8192));
    directed_rows.push_back(pix(0));
    // restart the frame mid-stream; stores keep their contents
    directed_rows.push_back(pix(100, 1'b1));
    directed_rows.push_back(pix(-100));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle_block();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_pixel(directed_rows[i].sample, directed_rows[i].frame_start,
                   directed_rows[i].known, directed_rows[i].result);
      end
    end

    // wide frame: every line store column that later frames reach gets
    // written at least twice
    settle_block();
    in_gap_max = 2;
    out_stall_max = 2;
    write_reg(REG_IMAGE_WIDTH, PRIME_WIDTH);
    write_reg(REG_NEIGHBOR_MODE, MODE_RING);
    write_reg(REG_EDGE_THRESHOLD, $urandom_range(0, 4096));
    for (n = 0; n < 3 * PRIME_WIDTH; n++) begin
      send_pixel(draw_sample(MIX_MID), n == 0, 1'b0, '0);
    end

    while (random_items < RANDOM_ITEMS) begin
      settle_block();
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      case ($urandom_range(0, 9))
        0:       new_width = $urandom_range(0, 2);
        1, 2, 3, 4, 5, 6: new_width = $urandom_range(3, 16);
        7, 8:    new_width = $urandom_range(17, 48);
        default: new_width = $urandom_range(49, PRIME_WIDTH);
      endcase
      case ($urandom_range(0, 7))
        0:       new_threshold = 0;
        1:       new_threshold = THR_MAX;
        2:       new_threshold = $urandom_range(0, THR_MAX);
        3, 4, 5: new_threshold = $urandom_range(0, 64);
        default: new_threshold = $urandom_range(0, 4096);
      endcase
      write_reg(REG_IMAGE_WIDTH, new_width);
      write_reg(REG_NEIGHBOR_MODE, $urandom_range(0, 1));
      write_reg(REG_EDGE_THRESHOLD, new_threshold);
      mix = sample_mix_t'($urandom_range(0, 3));
      span = (new_width < 3) ? 3 : new_width;
      count = span * $urandom_range(3, 6) + $urandom_range(0, span - 1);
      restart = ($urandom_range(0, 7) != 0);
      reshape_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, count - 1) : -1;
      for (n = 0; n < count && random_items < RANDOM_ITEMS; n++) begin
        if (n == reshape_at) begin
          // change the row length in the middle of a row
          settle_block();
          write_reg(REG_IMAGE_WIDTH, $urandom_range(3, 48));
        end else if ($urandom_range(0, 63) == 0) begin
          settle_block();
        end
        send_pixel(draw_sample(mix), (n == 0 && restart) || $urandom_range(0, 255) == 0,
                   1'b0, '0);
        random_items++;
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("log_zero_crossing_detector verification clean");
    end else begin
      $display("log_zero_crossing_detector verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/lzcd_pkg.sv
rtl/lzcd_judge.sv
rtl/log_zero_crossing_detector.sv
tb/sv/tb_log_zero_crossing_detector.sv
